@@ hw/rtl/jvfc_pkg.sv @@
// Shared types and constants for the joint velocity / friction compensation block.
// Holds the microcode word, the sequencer/datapath control structs and the register map.
// No dependencies.
package jvfc_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned RateW    = 17;
  localparam int unsigned DeadW    = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned PcW      = 3;
  localparam int unsigned MulW     = 33;
  localparam int unsigned ProdW    = 2 * MulW;
  localparam int unsigned SumW     = 52;
  localparam int unsigned DivW     = 56;
  localparam int unsigned DigitW   = 8;
  localparam int unsigned DivSteps = DivW / DigitW;
  localparam int unsigned CntW     = 3;

  // Reciprocal of three for a 10-bit partial dividend: q = (t * Recip3) >> Recip3Sh
  localparam int unsigned Recip3   = 683;
  localparam int unsigned Recip3Sh = 11;

  localparam logic [RateW-1:0] RateRst      = 17'd1000;
  localparam logic [DataW-1:0] SlopePosRst  = 32'sd16469;
  localparam logic [DataW-1:0] OffsetPosRst = 32'sd23835;
  localparam logic [DataW-1:0] SlopeNegRst  = 32'sd16233;
  localparam logic [DataW-1:0] OffsetNegRst = -32'sd19320;
  localparam logic [DataW-1:0] SlopeZeroRst = 32'sd235930;
  localparam logic [DeadW-1:0] DeadbandRst  = 31'd6554;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_RATE = 3'd0,
    REG_SLOPE_POS   = 3'd1,
    REG_OFFSET_POS  = 3'd2,
    REG_SLOPE_NEG   = 3'd3,
    REG_OFFSET_NEG  = 3'd4,
    REG_SLOPE_ZERO  = 3'd5,
    REG_DEADBAND    = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_WAIT_IN = 3'd0,
    OP_MUL_RAW = 3'd1,
    OP_SUM     = 3'd2,
    OP_DIV     = 3'd3,
    OP_VEL     = 3'd4,
    OP_MUL_TQ  = 3'd5,
    OP_TQ      = 3'd6,
    OP_NOP     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_NO_IN    = 2'd1,
    COND_DIV_MORE = 2'd2,
    COND_OUT_BUSY = 2'd3
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic           jump_always;
    logic [PcW-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic div_last;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic [RateW-1:0] sample_rate;
    logic [DataW-1:0] slope_pos;
    logic [DataW-1:0] offset_pos;
    logic [DataW-1:0] slope_neg;
    logic [DataW-1:0] offset_neg;
    logic [DataW-1:0] slope_zero;
    logic [DeadW-1:0] deadband;
  } cfg_t;

endpackage

@@ hw/rtl/jvfc_in_if.sv @@
// Input channel of the friction compensation block: one joint angle per item.
// Depends on jvfc_pkg for the field width.
interface jvfc_in_if;
  logic                        valid;
  logic                        ready;
  logic [jvfc_pkg::DataW-1:0]  joint_angle;

  modport source (output valid, output joint_angle, input ready);
  modport sink   (input valid, input joint_angle, output ready);
endinterface

@@ hw/rtl/jvfc_out_if.sv @@
// Output channel of the friction compensation block: velocity and torque per item.
// Depends on jvfc_pkg for the field widths.
interface jvfc_out_if;
  logic                        valid;
  logic                        ready;
  logic [jvfc_pkg::DataW-1:0]  velocity_estimate;
  logic [jvfc_pkg::DataW-1:0]  friction_torque;

  modport source (output valid, output velocity_estimate, output friction_torque, input ready);
  modport sink   (input valid, input velocity_estimate, input friction_torque, output ready);
endinterface

@@ hw/rtl/jvfc_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on jvfc_pkg.
module jvfc_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jvfc_pkg::stat_t stat_i,
  output jvfc_pkg::ctrl_t ctrl_o
);
  import jvfc_pkg::*;

  localparam int unsigned RomDepth = 2 ** PcW;

  localparam ucode_t Rom [RomDepth] = '{
    '{op: OP_WAIT_IN, cond: COND_NO_IN,    jump_always: 1'b0, target: 3'd0},
    '{op: OP_MUL_RAW, cond: COND_NONE,     jump_always: 1'b0, target: 3'd0},
    '{op: OP_SUM,     cond: COND_NONE,     jump_always: 1'b0, target: 3'd0},
    '{op: OP_DIV,     cond: COND_DIV_MORE, jump_always: 1'b0, target: 3'd3},
    '{op: OP_VEL,     cond: COND_NONE,     jump_always: 1'b0, target: 3'd0},
    '{op: OP_MUL_TQ,  cond: COND_NONE,     jump_always: 1'b0, target: 3'd0},
    '{op: OP_TQ,      cond: COND_OUT_BUSY, jump_always: 1'b0, target: 3'd6},
    '{op: OP_NOP,     cond: COND_NONE,     jump_always: 1'b1, target: 3'd0}
  };

  logic [PcW-1:0] pc_q, pc_d;
  ucode_t         uw;
  logic           take;

  assign uw = Rom[pc_q];

  always_comb begin
    case (uw.cond)
      COND_NONE:     take = 1'b0;
      COND_NO_IN:    take = !stat_i.in_valid;
      COND_DIV_MORE: take = !stat_i.div_last;
      COND_OUT_BUSY: take = stat_i.out_busy;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    if (take || uw.jump_always) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op = uw.op;

endmodule

@@ hw/rtl/jvfc_dp.sv @@
// Datapath: shared 33x33 multiplier, digit-serial divide by three, history and result registers.
// Depends on jvfc_pkg; driven by jvfc_seq control words.
module jvfc_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  jvfc_pkg::ctrl_t            ctrl_i,
  input  jvfc_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  input  logic [jvfc_pkg::DataW-1:0] in_angle_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [jvfc_pkg::DataW-1:0] out_vel_o,
  output logic [jvfc_pkg::DataW-1:0] out_tq_o,
  output jvfc_pkg::stat_t            stat_o
);
  import jvfc_pkg::*;

  localparam logic signed [DataW-1:0] SMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SMin = {1'b1, {(DataW-1){1'b0}}};

  logic signed [DataW-1:0] prev_q, h1_q, h2_q, vel_q;
  logic signed [MulW-1:0]  diff_q;
  logic signed [ProdW-1:0] mul_q;
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic [DivW-1:0]         num_q;
  logic [1:0]              rem_q;
  logic                    neg_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [DataW-1:0] off_q;
  logic                    out_valid_q;
  logic [DataW-1:0]        out_vel_q, out_tq_q;

  logic signed [SumW-1:0]  sum;
  logic [SumW-1:0]         mag;
  logic [9:0]              part;
  logic [19:0]             part_x;
  logic [DigitW-1:0]       digit;
  logic [1:0]              digit_rem;
  logic [DivW-1:0]         quo;
  logic signed [DataW-1:0] vel_sat;
  logic                    above, below;
  logic signed [DataW-1:0] slope_sel, off_sel;
  logic signed [ProdW-1:0] rounded;
  logic signed [48:0]      tq_sum;
  logic signed [DataW-1:0] tq_sat;
  logic                    accept;

  assign accept = (ctrl_i.op == OP_WAIT_IN) && in_valid_i;

  // Operand select for the shared multiplier
  always_comb begin
    if (ctrl_i.op == OP_MUL_TQ) begin
      mul_a = {slope_sel[DataW-1], slope_sel};
      mul_b = {vel_q[DataW-1], vel_q};
    end else begin
      mul_a = diff_q;
      mul_b = {{(MulW-RateW){1'b0}}, cfg_i.sample_rate};
    end
  end

  assign sum = mul_q[SumW-1:0]
             + {{(SumW-DataW){h1_q[DataW-1]}}, h1_q}
             + {{(SumW-DataW){h2_q[DataW-1]}}, h2_q};
  assign mag = sum[SumW-1] ? (~sum + 1'b1) : sum;

  // One base-256 digit of the quotient by three
  assign part      = {rem_q, num_q[DivW-1 -: DigitW]};
  assign part_x    = {10'd0, part} * 20'(Recip3);
  assign digit     = part_x[Recip3Sh +: DigitW];
  assign digit_rem = 2'(part - 10'(digit) * 10'd3);

  assign quo = num_q;
  always_comb begin
    if (!neg_q) begin
      vel_sat = (quo > DivW'(SMax)) ? SMax : quo[DataW-1:0];
    end else begin
      vel_sat = (quo > {{(DivW-DataW){1'b0}}, SMin}) ? SMin : DataW'(~quo + 1'b1);
    end
  end

  // Deadband region; the edges themselves fall inside
  assign above = $signed({vel_q[DataW-1], vel_q}) > $signed({2'b00, cfg_i.deadband});
  assign below = $signed({vel_q[DataW-1], vel_q}) < -$signed({2'b00, cfg_i.deadband});

  always_comb begin
    if (above) begin
      slope_sel = cfg_i.slope_pos;
      off_sel   = cfg_i.offset_pos;
    end else if (below) begin
      slope_sel = cfg_i.slope_neg;
      off_sel   = cfg_i.offset_neg;
    end else begin
      slope_sel = cfg_i.slope_zero;
      off_sel   = '0;
    end
  end

  assign rounded = (mul_q + ProdW'(32768)) >>> 16;
  assign tq_sum  = rounded[48:0] + {{17{off_q[DataW-1]}}, off_q};
  always_comb begin
    if (tq_sum > 49'(SMax)) begin
      tq_sat = SMax;
    end else if (tq_sum < $signed({{17{1'b1}}, SMin})) begin
      tq_sat = SMin;
    end else begin
      tq_sat = tq_sum[DataW-1:0];
    end
  end

  // Joint state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      h1_q        <= '0;
      h2_q        <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (accept) begin
        prev_q <= in_angle_i;
      end
      if (ctrl_i.op == OP_VEL) begin
        h2_q <= h1_q;
        h1_q <= vel_sat;
      end
      if (ctrl_i.op == OP_SUM) begin
        cnt_q <= CntW'(DivSteps - 1);
      end else if (ctrl_i.op == OP_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (ctrl_i.op == OP_TQ && !stat_o.out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_q <= {in_angle_i[DataW-1], in_angle_i} - {prev_q[DataW-1], prev_q};
    end
    if (ctrl_i.op == OP_MUL_RAW || ctrl_i.op == OP_MUL_TQ) begin
      mul_q <= mul_a * mul_b;
    end
    if (ctrl_i.op == OP_SUM) begin
      neg_q <= sum[SumW-1];
      num_q <= {{(DivW-SumW){1'b0}}, mag} + 1'b1;
      rem_q <= '0;
    end else if (ctrl_i.op == OP_DIV) begin
      num_q <= {num_q[DivW-DigitW-1:0], digit};
      rem_q <= digit_rem;
    end
    if (ctrl_i.op == OP_VEL) begin
      vel_q <= vel_sat;
    end
    if (ctrl_i.op == OP_MUL_TQ) begin
      off_q <= off_sel;
    end
    if (ctrl_i.op == OP_TQ && !stat_o.out_busy) begin
      out_vel_q <= vel_q;
      out_tq_q  <= tq_sat;
    end
  end

  assign stat_o.in_valid = in_valid_i;
  assign stat_o.div_last = (cnt_q == '0);
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_vel_o   = out_vel_q;
  assign out_tq_o    = out_tq_q;

endmodule

@@ hw/rtl/joint_velocity_friction_comp.sv @@
// Joint velocity estimate and viscous/Coulomb friction compensation, one joint.
// An item passes the raw multiply, sum, divide, velocity, torque multiply and torque steps;
// the program takes no new item until it is back at its wait step. Its divide-by-three
// runs one base-256 digit per step; a stalled output holds the program at its torque step.
// Reset (async, active low): config registers take their defaults, angle/velocity history
// clears to zero, the step counter returns to the input wait step and no result is valid.
module joint_velocity_friction_comp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [jvfc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [jvfc_pkg::DataW-1:0]   cfg_data_i,
  jvfc_in_if.sink                      in_i,
  jvfc_out_if.source                   out_o
);
  import jvfc_pkg::*;

  cfg_t  cfg_q;
  ctrl_t ctrl;
  stat_t stat;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate <= RateRst;
      cfg_q.slope_pos   <= SlopePosRst;
      cfg_q.offset_pos  <= OffsetPosRst;
      cfg_q.slope_neg   <= SlopeNegRst;
      cfg_q.offset_neg  <= OffsetNegRst;
      cfg_q.slope_zero  <= SlopeZeroRst;
      cfg_q.deadband    <= DeadbandRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SAMPLE_RATE: cfg_q.sample_rate <= cfg_data_i[RateW-1:0];
        REG_SLOPE_POS:   cfg_q.slope_pos   <= cfg_data_i;
        REG_OFFSET_POS:  cfg_q.offset_pos  <= cfg_data_i;
        REG_SLOPE_NEG:   cfg_q.slope_neg   <= cfg_data_i;
        REG_OFFSET_NEG:  cfg_q.offset_neg  <= cfg_data_i;
        REG_SLOPE_ZERO:  cfg_q.slope_zero  <= cfg_data_i;
        REG_DEADBAND:    cfg_q.deadband    <= cfg_data_i[DeadW-1:0];
        default: ;
      endcase
    end
  end

  // Program counter and control ROM
  jvfc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Arithmetic and the output register, which parts the two channels
  jvfc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_angle_i  (in_i.joint_angle),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_vel_o   (out_o.velocity_estimate),
    .out_tq_o    (out_o.friction_torque),
    .stat_o      (stat)
  );

  // Take an item only at the wait step, so one item is in flight at a time
  assign in_i.ready = (ctrl.op == OP_WAIT_IN);

`ifndef SYNTHESIS
  // One item at a time: after an accept the block stops taking items
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while an item is in flight");

  // A new result only comes from the torque step
  a_valid_from_tq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(ctrl.op == OP_TQ))
    else $error("result valid rose outside the torque step");

  // A stalled output holds the program at the torque step
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_TQ && out_o.valid && !out_o.ready) |=> (ctrl.op == OP_TQ))
    else $error("program left the torque step while the output was stalled");
`endif

endmodule
